// ===== rtl/core/gf2gcd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gf2gcd_pkg: shared types and constants for the GF(2) polynomial GCD core
// Polynomial width, degree counter width, datapath operation codes and the
// status word that the datapath returns to the sequencer.
// ---------------------------------------------------------------------------
package gf2gcd_pkg;

  // Port width of every polynomial field
  localparam int unsigned DATA_W = 64;
  // Number of coefficient bits used (8..64); bits above are ignored
  localparam int unsigned POLY_W = 64;
  localparam int unsigned DEG_W  = $clog2(POLY_W);

  typedef logic [POLY_W-1:0] poly_t;
  typedef logic [DEG_W-1:0]  deg_t;

  localparam deg_t DEG_TOP = deg_t'(POLY_W - 1);

  // Operations of the shared shift/XOR unit
  typedef enum logic [2:0] {
    DP_HOLD,
    DP_LOAD,
    DP_NORM_B,
    DP_SHIFT_A,
    DP_REDUCE,
    DP_SWAP
  } dp_op_e;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic a_zero;
    logic a_top;
    logic b_zero;
    logic b_top;
    logic a_ge_b;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/gf2gcd_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gf2gcd_datapath: shared shift-and-XOR unit of the GCD core
// Holds both operands left-aligned (leading coefficient at the top bit) with
// their degrees. One operation per cycle: load, align, reduce, swap.
// ---------------------------------------------------------------------------
module gf2gcd_datapath (
  input  logic                   clk_i,
  input  gf2gcd_pkg::dp_op_e     op_i,
  input  gf2gcd_pkg::poly_t      a_i,
  input  gf2gcd_pkg::poly_t      b_i,
  output gf2gcd_pkg::dp_status_t status_o,
  output gf2gcd_pkg::poly_t      result_o
);
  import gf2gcd_pkg::*;

  poly_t a_q, a_d, b_q, b_d;
  deg_t  deg_a_q, deg_a_d, deg_b_q, deg_b_d;

  // Next-value logic for the operand registers
  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    deg_a_d = deg_a_q;
    deg_b_d = deg_b_q;
    case (op_i)
      DP_LOAD: begin
        // zero divisor: park the dividend in B so the result path is uniform
        if (b_i == '0) begin
          a_d = '0;
          b_d = a_i;
        end else begin
          a_d = a_i;
          b_d = b_i;
        end
        deg_a_d = DEG_TOP;
        deg_b_d = DEG_TOP;
      end
      DP_NORM_B: begin
        b_d     = {b_q[POLY_W-2:0], 1'b0};
        deg_b_d = deg_b_q - deg_t'(1);
      end
      DP_SHIFT_A: begin
        a_d     = {a_q[POLY_W-2:0], 1'b0};
        deg_a_d = deg_a_q - deg_t'(1);
      end
      DP_REDUCE: begin
        // both aligned: cancels the leading term of A
        a_d = a_q ^ b_q;
      end
      DP_SWAP: begin
        a_d     = b_q;
        b_d     = a_q;
        deg_a_d = deg_b_q;
        deg_b_d = deg_a_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    deg_a_q <= deg_a_d;
    deg_b_q <= deg_b_d;
  end

  // Status for the sequencer
  assign status_o.a_zero = (a_q == '0);
  assign status_o.a_top  = a_q[POLY_W-1];
  assign status_o.b_zero = (b_q == '0);
  assign status_o.b_top  = b_q[POLY_W-1];
  assign status_o.a_ge_b = (deg_a_q >= deg_b_q);

  // Undo the alignment of B
  assign result_o = b_q >> (DEG_TOP - deg_b_q);

endmodule
`default_nettype wire

// ===== rtl/core/gf2_polynomial_gcd_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gf2_polynomial_gcd_core: GCD of two GF(2) polynomials by Euclid's algorithm
// Bit k of a word is the coefficient of x^k. Result is the last nonzero
// remainder; zero only when both operands are zero.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries poly_a_i and poly_b_i; only
//   the low POLY_W bits are used. Output channel (out_valid_o/out_ready_i)
//   carries gcd_poly_o. One result transaction per input transaction.
//   The core works on one item at a time: in_ready_o is high only while idle.
//   A single shift/XOR unit does one step per cycle. First B is aligned,
//   then each cycle either shifts A by one, XORs B into A, or swaps A and
//   B; a zero divisor or zero operand ends the computation early.
//   A finished result is held in the output register until taken; while the
//   receiver stalls, no new item is accepted.
//   Reset (rst_ni low, asynchronous) returns the core to idle and drops any
//   pending result.
// ---------------------------------------------------------------------------
module gf2_polynomial_gcd_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gf2gcd_pkg::DATA_W-1:0]   poly_a_i,
  input  logic [gf2gcd_pkg::DATA_W-1:0]   poly_b_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gf2gcd_pkg::DATA_W-1:0]   gcd_poly_o
);
  import gf2gcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_RUN,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   gcd_q;
  dp_op_e              op;
  dp_status_t          status;
  poly_t               result;

  gf2gcd_datapath u_datapath (
    .clk_i    (clk_i),
    .op_i     (op),
    .a_i      (poly_a_i[POLY_W-1:0]),
    .b_i      (poly_b_i[POLY_W-1:0]),
    .status_o (status),
    .result_o (result)
  );

  // Operation select for the shared unit
  always_comb begin
    op = DP_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) op = DP_LOAD;
      end
      ST_NORM: begin
        if (!status.b_zero && !status.b_top) op = DP_NORM_B;
      end
      ST_RUN: begin
        if (status.a_zero)      op = DP_HOLD;
        else if (!status.a_top) op = DP_SHIFT_A;
        else if (status.a_ge_b) op = DP_REDUCE;
        else                    op = DP_SWAP;
      end
      default: op = DP_HOLD;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      gcd_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (status.b_zero) begin
            // both operands zero
            gcd_q       <= DATA_W'(result);
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else if (status.b_top) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          // remainder zero: B holds the gcd
          if (status.a_zero) begin
            gcd_q       <= DATA_W'(result);
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign gcd_poly_o  = gcd_q;

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a result is pending");

  a_b_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> status.b_top)
    else $error("divisor lost its alignment during reduction");

  a_reduce_cancels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == DP_REDUCE) |=> !status.a_top)
    else $error("XOR step did not cancel the leading term");

  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == DP_SWAP) |=> status.a_ge_b && status.b_top)
    else $error("swap left operands out of degree order");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_NORM))
    else $error("accepted item did not start the computation");

endmodule
`default_nettype wire
